@@ hdl/clock_page_replacement_macros.svh @@
// assertion macros for the clock page replacement block
`ifndef CLOCK_PAGE_REPLACEMENT_MACROS_SVH
`define CLOCK_PAGE_REPLACEMENT_MACROS_SVH

// same-cycle implication
`define CPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/cpr_pkg.sv @@
// package with shared types and constants for the clock page replacement block
package cpr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;
  localparam int CFG_W         = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_SWEEP
  } st_t;

  typedef struct packed {
    logic restart;
    logic step;
    logic write;
  } cell_ctl_t;

endpackage

@@ hdl/cpr_cell.sv @@
// one page frame of the clock ring with its slot of the hand token
module cpr_cell
  import cpr_pkg::*;
#(
  parameter int   PAGE_BITS  = PAGE_BITS_DEF,
  parameter logic TOKEN_INIT = 1'b0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [PAGE_BITS-1:0] page_cmp,
  input  logic                 set_ref,
  input  logic                 last,
  input  logic                 tok_in,
  output logic                 tok_out,
  output logic                 tok,
  output logic                 match,
  output logic                 frame_valid,
  output logic                 ref_bit,
  output logic [PAGE_BITS-1:0] frame_page
);

  logic take;

  assign take    = ctl.write && tok;
  assign match   = frame_valid && (frame_page == page_cmp);
  assign tok_out = tok && !last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok         <= TOKEN_INIT;
      ref_bit     <= 1'b0;
      frame_valid <= 1'b0;
    end else begin
      if (ctl.restart) begin
        tok <= TOKEN_INIT;
      end else if (ctl.step) begin
        tok <= tok_in;
      end
      if (ctl.step && tok) begin
        ref_bit <= 1'b0;
      end else if (take || set_ref) begin
        ref_bit <= 1'b1;
      end
      if (take) begin
        frame_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      frame_page <= page_cmp;
    end
  end

endmodule

@@ hdl/clock_page_replacement.sv @@
// top level of the clock (second chance) page replacement block
//
// Usage: each word on the input channel (in_valid / in_stall, field page) is one
// page reference. Each reference yields exactly one result word on the output
// channel (out_valid / out_stall): fault, frame_index, evicted_valid and
// evicted_page. The frame count is written through cfg_valid / cfg_ready with
// frames_in_use; cfg_ready is always high. The user must write it only while
// the block is idle; the block itself does not enforce this. Frames form a ring
// of cells; the hand is a token passed from cell to cell. A hit is compared and
// its result registered with no sweep; a fault first sweeps, the hand clearing
// k (0 .. n) set reference bits, one frame per cycle, then writes the victim
// frame and loads the result. The next reference is taken only after the
// result is loaded. A finished result sits in the output register while the
// next reference is accepted; a stalled output only holds back completion of
// the next item. Reset (rst, synchronous) empties all frames, clears
// reference bits, puts the hand on frame 0 and sets frames_in_use to 8.
module clock_page_replacement
  import cpr_pkg::*;
#(
  parameter int FRAMES    = FRAMES_DEF,
  parameter int PAGE_BITS = PAGE_BITS_DEF,
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_W-1:0]     frames_in_use,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAGE_BITS-1:0] page,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 fault,
  output logic [IDX_W-1:0]     frame_index,
  output logic                 evicted_valid,
  output logic [PAGE_BITS-1:0] evicted_page
);

`include "clock_page_replacement_macros.svh"

  st_t                  st, st_next;
  logic [CFG_W-1:0]     count_cfg;
  logic [PAGE_BITS-1:0] req_page;
  cell_ctl_t            ctl;

  logic [FRAMES-1:0]    in_range, last, tok, tok_in, tok_out, match, valid_v, ref_v;
  logic [FRAMES-1:0]    hit_vec, hit_sel, set_ref;
  logic [PAGE_BITS-1:0] pages [FRAMES];

  logic                 any_hit, tok_oor, tok_ref, out_free, hit_done;
  logic [IDX_W-1:0]     hit_idx, tok_idx;
  logic                 vic_valid;
  logic [PAGE_BITS-1:0] vic_page;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      count_cfg <= frames_in_use;
    end
  end

  // frame i is in use when i < clamp(count, 1, FRAMES)
  for (genvar gi = 0; gi < FRAMES; gi++) begin : g_range
    if (gi == 0) begin : g_first
      assign in_range[gi] = 1'b1;
    end else begin : g_rest
      assign in_range[gi] = {{(32-CFG_W){1'b0}}, count_cfg} > 32'(gi);
    end
    if (gi == FRAMES - 1) begin : g_end
      assign last[gi]   = in_range[gi];
    end else begin : g_mid
      assign last[gi]   = in_range[gi] && !in_range[gi+1];
    end
  end

  // token ring with wrap at the last frame in use
  assign tok_in[0] = |(tok & last);
  for (genvar gi = 1; gi < FRAMES; gi++) begin : g_ring
    assign tok_in[gi] = tok_out[gi-1];
  end

  for (genvar gi = 0; gi < FRAMES; gi++) begin : g_cell
    cpr_cell #(
      .PAGE_BITS  (PAGE_BITS),
      .TOKEN_INIT (gi == 0)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .page_cmp    (req_page),
      .set_ref     (set_ref[gi]),
      .last        (last[gi]),
      .tok_in      (tok_in[gi]),
      .tok_out     (tok_out[gi]),
      .tok         (tok[gi]),
      .match       (match[gi]),
      .frame_valid (valid_v[gi]),
      .ref_bit     (ref_v[gi]),
      .frame_page  (pages[gi])
    );
  end

  assign hit_vec  = match & in_range;
  assign hit_sel  = hit_vec & (~hit_vec + FRAMES'(1));
  assign any_hit  = |hit_vec;
  assign tok_oor  = |(tok & ~in_range);
  assign tok_ref  = |(tok & ref_v);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    hit_idx   = '0;
    tok_idx   = '0;
    vic_valid = 1'b0;
    vic_page  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (hit_sel[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
      if (tok[i]) begin
        tok_idx = tok_idx | IDX_W'(i);
      end
      if (tok[i] && valid_v[i]) begin
        vic_valid = 1'b1;
        vic_page  = vic_page | pages[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE: begin
        if (in_valid) begin
          st_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (!any_hit) begin
          st_next = ST_SWEEP;
        end else if (out_free) begin
          st_next = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        if (!tok_ref && out_free) begin
          st_next = ST_IDLE;
        end
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = (st != ST_IDLE);
    ctl.restart = (st == ST_CMP) && !any_hit && tok_oor;
    ctl.step    = (st == ST_SWEEP) && tok_ref;
    ctl.write   = (st == ST_SWEEP) && !tok_ref && out_free;
    hit_done    = (st == ST_CMP) && any_hit && out_free;
    set_ref     = hit_done ? hit_sel : '0;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_page <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hit_done || ctl.write) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit_done) begin
      fault         <= 1'b0;
      frame_index   <= hit_idx;
      evicted_valid <= 1'b0;
      evicted_page  <= '0;
    end else if (ctl.write) begin
      fault         <= 1'b1;
      frame_index   <= tok_idx;
      evicted_valid <= vic_valid;
      evicted_page  <= vic_page;
    end
  end

  // hand token stays unique
  `CPR_ASSERT_NOW(a_tok_onehot, 1'b1, $onehot(tok), "hand token not one-hot")
  // a displaced page only comes with a fault
  `CPR_ASSERT_NOW(a_evict_fault, out_valid && evicted_valid, fault, "eviction without fault")
  // victim write completes the item
  `CPR_ASSERT_NEXT(a_write_done, ctl.write, (st == ST_IDLE) && out_valid,
                   "victim write did not finish item")
  // an accepted word goes to the compare step
  `CPR_ASSERT_NEXT(a_accept_cmp, in_valid && !in_stall, st == ST_CMP,
                   "accepted word not compared")

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the clock page replacement block
`timescale 1ns / 1ps

module testbench;
  import cpr_pkg::*;

  typedef enum bit {WK_REF, WK_CFG} word_kind_t;

  typedef struct {
    word_kind_t      kind;
    bit [15:0]       page;
    bit [CFG_W-1:0]  count;
  } stim_word_t;

  typedef struct {
    bit        fault;
    bit [2:0]  frame_index;
    bit        evicted_valid;
    bit [15:0] evicted_page;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] frames_in_use = CFG_RESET;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [15:0]      page = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             fault;
  logic [2:0]       frame_index;
  logic             evicted_valid;
  logic [15:0]      evicted_page;

  clock_page_replacement i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .frames_in_use (frames_in_use),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .page          (page),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .fault         (fault),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
  );

  stim_word_t stim_words[$];
  result_t    pending_results[$];
  int         errors = 0;

  bit [15:0]      frame_pages[8];
  bit             frame_used[8];
  bit             ref_bits[8];
  int             hand_pos = 0;
  bit [CFG_W-1:0] frames_cfg = CFG_RESET;

  bit in_pend = 1'b0;
  bit cfg_pend = 1'b0;
  bit in_taken = 1'b0;
  bit cfg_taken = 1'b0;
  int in_gap = 0;
  int stall_left = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  initial begin
    #2ms;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic result_t replace_page(bit [15:0] pg);
    result_t r;
    int n;
    int visits;
    n = (frames_cfg == 0) ? 1 : ((frames_cfg > 8) ? 8 : int'(frames_cfg));
    r = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if (frame_used[i] && frame_pages[i] == pg) begin
        ref_bits[i] = 1'b1;
        r.frame_index = 3'(i);
        return r;
      end
    end
    if (hand_pos >= n) hand_pos = 0;
    visits = 0;
    while (visits <= n && ref_bits[hand_pos]) begin
      ref_bits[hand_pos] = 1'b0;
      hand_pos = (hand_pos + 1 >= n) ? 0 : hand_pos + 1;
      visits++;
    end
    r.fault = 1'b1;
    r.frame_index = 3'(hand_pos);
    if (frame_used[hand_pos]) begin
      r.evicted_valid = 1'b1;
      r.evicted_page = frame_pages[hand_pos];
    end
    frame_pages[hand_pos] = pg;
    frame_used[hand_pos] = 1'b1;
    ref_bits[hand_pos] = 1'b1;
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_val, act_val);
      errors++;
    end
  endtask

  task automatic add_ref(bit [15:0] pg);
    stim_words.push_back('{kind: WK_REF, page: pg, count: '0});
  endtask

  task automatic add_cfg(bit [CFG_W-1:0] cnt);
    stim_words.push_back('{kind: WK_CFG, page: '0, count: cnt});
  endtask

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        pending_results.push_back(replace_page(page));
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        frames_cfg = frames_in_use;
        cfg_taken = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got = '{fault, frame_index, evicted_valid, evicted_page};
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result word: fault %0h frame %0h evicted %0h/%0h",
                   $time, got.fault, got.frame_index, got.evicted_valid, got.evicted_page);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("fault", int'(want.fault), int'(got.fault));
          check_field("frame_index", int'(want.frame_index), int'(got.frame_index));
          check_field("evicted_valid", int'(want.evicted_valid), int'(got.evicted_valid));
          check_field("evicted_page", int'(want.evicted_page), int'(got.evicted_page));
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    stim_word_t w;
    if (!rst) begin
      if (in_taken) in_pend = 1'b0;
      if (cfg_taken) cfg_pend = 1'b0;
      in_taken = 1'b0;
      cfg_taken = 1'b0;
      if (!in_pend && !cfg_pend) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (stim_words.size() > 0) begin
          w = stim_words[0];
          if (w.kind == WK_REF) begin
            void'(stim_words.pop_front());
            page <= w.page;
            in_pend = 1'b1;
          end else if (pending_results.size() == 0) begin
            void'(stim_words.pop_front());
            frames_in_use <= w.count;
            cfg_pend = 1'b1;
          end
          if (stim_words.size() > 60 && $urandom_range(0, 4) == 0)
            in_gap = $urandom_range(1, 19);
        end
      end
      in_valid <= in_pend;
      cfg_valid <= cfg_pend;
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (stim_words.size() > 60 && $urandom_range(0, 5) == 0)
          stall_left = $urandom_range(1, 19);
      end
    end
  end

  initial begin
    bit [15:0] pool[$];
    int        pool_n;
    for (int i = 0; i < 8; i++) begin
      frame_pages[i] = '0;
      frame_used[i] = 1'b0;
      ref_bits[i] = 1'b0;
    end

    // fill all frames, then hit and a full sweep
    add_ref(16'h0000);
    add_ref(16'hFFFF);
    add_ref(16'h5555);
    add_ref(16'hAAAA);
    add_ref(16'h0001);
    add_ref(16'h0002);
    add_ref(16'h0003);
    add_ref(16'h0004);
    add_ref(16'hFFFF);
    add_ref(16'h1234);
    add_ref(16'h0002);
    // page held only beyond the frame count
    add_cfg(4'd2);
    add_ref(16'hAAAA);
    add_ref(16'h00FF);
    // count zero, hand beyond count
    add_cfg(4'd0);
    add_ref(16'h00FF);
    add_ref(16'hBEEF);
    // count above the frame total, duplicate page
    add_cfg(4'd15);
    add_ref(16'hAAAA);
    add_ref(16'hBEEF);
    add_cfg(4'd8);
    add_ref(16'h7FFF);
    add_ref(16'h8000);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: add_cfg(4'd1);
        1: add_cfg(4'd8);
        2: add_cfg(4'd0);
        3: add_cfg(4'd15);
        default: add_cfg(CFG_W'($urandom_range(0, 15)));
      endcase
      pool.delete();
      pool_n = $urandom_range(2, 12);
      for (int i = 0; i < pool_n; i++) pool.push_back(16'($urandom));
      for (int i = 0; i < 50; i++) begin
        if ($urandom_range(0, 99) < 85) add_ref(pool[$urandom_range(0, pool_n - 1)]);
        else add_ref(16'($urandom));
      end
    end

    wait (!rst);
    wait (stim_words.size() == 0 && !in_pend && !cfg_pend && pending_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ clock_page_replacement.f @@
+incdir+hdl
hdl/cpr_pkg.sv
hdl/cpr_cell.sv
hdl/clock_page_replacement.sv
sim/testbench.sv
